### rtl/core/hdaf_pkg.sv
// shared types, command codes and digit helpers for the hex/decimal ascii formatter
package hdaf_pkg;

  localparam logic [2:0] CMD_HEX2 = 3'd0;
  localparam logic [2:0] CMD_HEX4 = 3'd1;
  localparam logic [2:0] CMD_HEX8 = 3'd2;
  localparam logic [2:0] CMD_DEC4 = 3'd3;
  localparam logic [2:0] CMD_DEC8 = 3'd4;
  localparam logic [2:0] CMD_RAW  = 3'd5;

  localparam int VALUE_W = 32;
  localparam int DIGITS = 10;
  localparam int BCD_W = 4 * DIGITS;
  localparam int STEPS_PER_STAGE = 8;
  localparam int CONV_STAGES = VALUE_W / STEPS_PER_STAGE;
  localparam int MAX_CHARS = 8;
  localparam int COUNT_W = 4;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [VALUE_W-1:0] value;
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
  } conv_t;

  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [COUNT_W-1:0]        count;
  } run_t;

  function automatic logic [7:0] digit_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + {4'h0, n};
    end else begin
      c = 8'h41 + {4'h0, n} - 8'd10;
    end
    return c;
  endfunction

  // one shift-and-add-3 step of the binary to bcd conversion
  function automatic conv_t dd_step(input conv_t c);
    conv_t r;
    logic [BCD_W-1:0] adj;
    r = c;
    adj = c.bcd;
    for (int k = 0; k < DIGITS; k++) begin
      if (adj[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = adj[4*k +: 4] + 4'd3;
      end
    end
    {r.bcd, r.bin} = {adj[BCD_W-2:0], c.bin, 1'b0};
    return r;
  endfunction

endpackage

### rtl/core/hdaf_conv_stage.sv
// one register stage of the pipelined binary to bcd converter
module hdaf_conv_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hdaf_pkg::conv_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hdaf_pkg::conv_t out_data
);
  import hdaf_pkg::*;

  conv_t stepped;

  always_comb begin
    stepped = in_data;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      stepped = dd_step(stepped);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stepped;
    end
  end

endmodule

### rtl/core/hdaf_format.sv
// picks the digits for the command and builds the character run
module hdaf_format (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  hdaf_pkg::conv_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output hdaf_pkg::run_t  out_data
);
  import hdaf_pkg::*;

  logic [DIGITS-1:0][3:0] d;
  logic [7:0] sum8;
  logic [7:0] sum4;
  run_t run;

  assign d = in_data.bcd;

  // leading digit is the quotient mod 16: 100 = 4 and 10 = 10 mod 16
  assign sum8 = {2'b0, d[9], 2'b0} + {1'b0, d[8], 3'b0} + {3'b0, d[8], 1'b0} + {4'b0, d[7]};
  assign sum4 = {1'b0, d[4], 3'b0} + {3'b0, d[4], 1'b0} + {4'b0, d[3]};

  always_comb begin
    run.chars = '0;
    run.count = '0;
    case (in_data.cmd)
      CMD_HEX2: begin
        for (int i = 0; i < 2; i++) begin
          run.chars[i] = digit_char(in_data.value[4*(1-i) +: 4]);
        end
        run.count = COUNT_W'(2);
      end
      CMD_HEX4: begin
        for (int i = 0; i < 4; i++) begin
          run.chars[i] = digit_char(in_data.value[4*(3-i) +: 4]);
        end
        run.count = COUNT_W'(4);
      end
      CMD_HEX8: begin
        for (int i = 0; i < 8; i++) begin
          run.chars[i] = digit_char(in_data.value[4*(7-i) +: 4]);
        end
        run.count = COUNT_W'(8);
      end
      CMD_DEC4: begin
        run.chars[0] = digit_char(sum4[3:0]);
        for (int i = 1; i < 4; i++) begin
          run.chars[i] = digit_char(d[3-i]);
        end
        run.count = COUNT_W'(4);
      end
      CMD_DEC8: begin
        run.chars[0] = digit_char(sum8[3:0]);
        for (int i = 1; i < 8; i++) begin
          run.chars[i] = digit_char(d[7-i]);
        end
        run.count = COUNT_W'(8);
      end
      CMD_RAW: begin
        run.chars[0] = in_data.value[7:0];
        run.count = (in_data.value[7:0] != 8'h00) ? COUNT_W'(1) : COUNT_W'(0);
      end
      default: begin
        run.count = '0;
      end
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= run;
    end
  end

endmodule

### rtl/core/hdaf_serializer.sv
// shifts a character run out one beat at a time
module hdaf_serializer (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hdaf_pkg::run_t in_data,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tlast
);
  import hdaf_pkg::*;

  logic [MAX_CHARS-1:0][7:0] chars;
  logic [COUNT_W-1:0] cnt;

  assign m_tvalid = cnt != '0;
  assign m_tlast = cnt == COUNT_W'(1);
  assign m_tdata = chars[0];

  // a new run loads when the buffer is empty or its last beat leaves now
  assign in_ready = (cnt == '0) || (m_tlast && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (in_ready && in_valid) begin
      cnt <= in_data.count;
    end else if (m_tvalid && m_tready) begin
      cnt <= cnt - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      chars <= in_data.chars;
    end else if (m_tvalid && m_tready) begin
      chars <= {8'h00, chars[MAX_CHARS-1:1]};
    end
  end

endmodule

### rtl/core/hex_decimal_ascii_formatter.sv
// Top level of the hex/decimal ascii formatter.
// Path: an input beat passes through four converter stages and the format stage,
// then the output shift register loads its run and m_tvalid rises.
// Output: one character per beat while m_tready is high, from the output shift
// register; a run holds 0 to 8 characters, the next loads as its last beat leaves.
// Reset: rst is synchronous, active high, and empties every stage.
module hex_decimal_ascii_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value
  input  logic [2:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // character
  output logic        m_tlast    // last_char
);
  import hdaf_pkg::*;

  conv_t stg_data [CONV_STAGES+1];
  logic  stg_valid [CONV_STAGES+1];
  logic  stg_ready [CONV_STAGES+1];

  logic fmt_valid;
  logic fmt_ready;
  run_t fmt_data;

  // fields from msb: cmd, value, bcd, bin
  assign stg_data[0] = {s_tuser, s_tdata, {BCD_W{1'b0}},
                        (s_tuser == CMD_DEC4) ? {16'h0000, s_tdata[15:0]} : s_tdata};
  assign stg_valid[0] = s_tvalid;
  assign s_tready = stg_ready[0];

  for (genvar g = 0; g < CONV_STAGES; g++) begin : g_conv
    hdaf_conv_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[g]),
      .in_ready  (stg_ready[g]),
      .in_data   (stg_data[g]),
      .out_valid (stg_valid[g+1]),
      .out_ready (stg_ready[g+1]),
      .out_data  (stg_data[g+1])
    );
  end

  hdaf_format u_format (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stg_valid[CONV_STAGES]),
    .in_ready  (stg_ready[CONV_STAGES]),
    .in_data   (stg_data[CONV_STAGES]),
    .out_valid (fmt_valid),
    .out_ready (fmt_ready),
    .out_data  (fmt_data)
  );

  hdaf_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fmt_valid),
    .in_ready (fmt_ready),
    .in_data  (fmt_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTH
  // a run never holds more characters than the buffer
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    fmt_valid |-> (fmt_data.count <= COUNT_W'(MAX_CHARS)))
    else $error("character run longer than buffer");

  // a run is not broken before its last character
  a_run_whole: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("run broken before last character");

  // an accepted beat lands in the first converter stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> stg_valid[1])
    else $error("accepted beat lost at pipeline entry");

  // reset leaves nothing to send
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule

### verif/tb_hex_decimal_ascii_formatter.sv
// self-checking testbench for the hex/decimal ascii formatter, predicted character runs vs stream output
`timescale 1ns / 1ps

module tb_hex_decimal_ascii_formatter;
  import hdaf_pkg::*;

  // codes outside the defined command set, the block drops them
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } char_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;  // value
  logic [2:0]  s_tuser = '0;  // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;       // character
  logic        m_tlast;       // last_char

  char_beat_t pending_chars[$];
  char_beat_t want;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int items_taken = 0;
  int chars_seen = 0;
  int cycles = 0;

  hex_decimal_ascii_formatter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h41 + {4'h0, n} - 8'd10;
  endfunction

  // expected characters of one accepted item, appended to pending_chars
  function automatic void format_item(input logic [2:0] cmd, input logic [31:0] value);
    logic [7:0]  run[$];
    logic [31:0] rest;
    logic [31:0] weight;
    logic [31:0] quot;
    int          ndig;
    bit          decimal;
    char_beat_t  b;
    ndig = 0;
    decimal = 1'b0;
    rest = value;
    weight = 32'd1;
    case (cmd)
      CMD_HEX2: begin
        ndig = 2;
      end
      CMD_HEX4: begin
        ndig = 4;
      end
      CMD_HEX8: begin
        ndig = 8;
      end
      CMD_DEC4: begin
        ndig = 4;
        decimal = 1'b1;
        rest = {16'h0000, value[15:0]};
        weight = 32'd1000;
      end
      CMD_DEC8: begin
        ndig = 8;
        decimal = 1'b1;
        weight = 32'd10000000;
      end
      CMD_RAW: begin
        if (value[7:0] != 8'h00) run.push_back(value[7:0]);
      end
      default: begin
      end
    endcase
    for (int i = 0; i < ndig; i++) begin
      if (decimal) begin
        // leading digit may exceed 9 and is shown as a hex nibble
        quot = rest / weight;
        run.push_back(nibble_ascii(quot[3:0]));
        rest = rest % weight;
        weight = weight / 32'd10;
      end else begin
        run.push_back(nibble_ascii(rest[4*(ndig-1-i) +: 4]));
      end
    end
    foreach (run[k]) begin
      b.character = run[k];
      b.last_char = (k == run.size() - 1);
      pending_chars.push_back(b);
    end
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic send_item(input logic [2:0] cmd, input logic [31:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= value;
    do @(posedge clk); while (s_tready !== 1'b1);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // output check first, then prediction for a beat taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        chars_seen++;
        if (pending_chars.size() == 0) begin
          note_error($sformatf("unexpected character %h last %b", m_tdata, m_tlast));
        end else begin
          want = pending_chars.pop_front();
          if (m_tdata !== want.character || m_tlast !== want.last_char) begin
            note_error($sformatf("character exp %h got %h, last exp %b got %b",
                                 want.character, m_tdata, want.last_char, m_tlast));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        items_taken++;
        format_item(s_tuser, s_tdata);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("hex_decimal_ascii_formatter test failed");
      $finish;
    end
  end

  task automatic test_hex_forms;
    send_item(CMD_HEX2, 32'h0000_0000);
    send_item(CMD_HEX2, 32'hABCD_EF5A);
    send_item(CMD_HEX4, 32'h0000_0000);
    send_item(CMD_HEX4, 32'h0000_FFFF);
    send_item(CMD_HEX4, 32'h1234_9ABC);
    send_item(CMD_HEX8, 32'h0000_0000);
    send_item(CMD_HEX8, 32'hFFFF_FFFF);
    send_item(CMD_HEX8, 32'h0123_4567);
    send_item(CMD_HEX8, 32'h89AB_CDEF);
  endtask

  task automatic test_decimal_forms;
    send_item(CMD_DEC4, 32'd0);
    send_item(CMD_DEC4, 32'd9999);
    // leading digit above nine turns into a letter
    send_item(CMD_DEC4, 32'd10000);
    send_item(CMD_DEC4, 32'd65535);
    send_item(CMD_DEC4, 32'hFFFF_0000 | 32'd1234);
    send_item(CMD_DEC8, 32'd0);
    send_item(CMD_DEC8, 32'd99999999);
    send_item(CMD_DEC8, 32'd100000000);
    send_item(CMD_DEC8, 32'd159999999);
    send_item(CMD_DEC8, 32'hFFFF_FFFF);
  endtask

  task automatic test_raw_and_unused;
    send_item(CMD_RAW, 32'h0000_0041);
    send_item(CMD_RAW, 32'hFFFF_FFFF);
    // zero byte gives an empty run
    send_item(CMD_RAW, 32'h0000_0000);
    send_item(CMD_RAW, 32'h1234_5600);
    send_item(CMD_SPARE_A, 32'hFFFF_FFFF);
    send_item(CMD_SPARE_B, 32'h1234_5678);
  endtask

  task automatic test_mixed_random(input int n);
    int          made;
    logic [2:0]  cmd;
    logic [31:0] value;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 11) == 0) begin
        cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
      end else begin
        cmd = 3'($urandom_range(CMD_HEX2, CMD_RAW));
      end
      value = $urandom;
      case ($urandom_range(0, 3))
        1: value = $urandom_range(0, 15);
        2: value = (cmd == CMD_DEC8) ? $urandom_range(0, 99999999)
                                     : ((value & 32'hFFFF_0000) | $urandom_range(0, 9999));
        3: value = (cmd == CMD_DEC8) ? $urandom_range(99999990, 159999999)
                                     : ((value & 32'hFFFF_0000) | $urandom_range(9990, 16999));
        default: begin
        end
      endcase
      send_item(cmd, value);
      made++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_hex_forms();
    test_decimal_forms();
    test_raw_and_unused();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_mixed_random(39);
    send_idle_pct = 70;
    recv_stall_pct = 0;
    test_mixed_random(39);
    send_idle_pct = 0;
    recv_stall_pct = 70;
    test_mixed_random(39);
    send_idle_pct = 9;
    recv_stall_pct = 9;
    test_mixed_random(39);
    s_tvalid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pending_chars.size() != 0) begin
      note_error($sformatf("%0d characters never arrived", pending_chars.size()));
    end

    $display("ran %0d items through all six commands and four idle/stall mixes", items_taken);
    $display("checked %0d characters, %0d mismatches", chars_seen, errors);
    if (errors == 0) begin
      $display("hex_decimal_ascii_formatter test passed");
    end else begin
      $display("hex_decimal_ascii_formatter test failed");
    end
    $finish;
  end

endmodule
